// ===== design/lrp_pkg.sv =====
// shared types, codes and helpers for the lmtp reply parser
package lrp_pkg;

	// request codes
	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_EOS  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOT_OK   = 3'd1;
	localparam logic [2:0] ST_FORMAT   = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;
	localparam logic [2:0] ST_EOS      = 3'd5;

	// register indexes
	localparam logic [1:0] REG_OK_DIGIT      = 2'd0;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
	localparam logic [1:0] REG_BUFFER_LIMIT  = 2'd2;

	// register reset values
	localparam logic [5:0]  OK_DIGIT_RST      = 6'd50;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd300;
	localparam logic [15:0] BUFFER_LIMIT_RST  = 16'd1024;

	// characters
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// budget that must remain before a byte is taken
	localparam logic [16:0] BUDGET_MARGIN = 17'd10;

	// fourth character classes
	localparam logic [1:0] FC_ABSENT = 2'd0;
	localparam logic [1:0] FC_DASH   = 2'd1;
	localparam logic [1:0] FC_SPACE  = 2'd2;
	localparam logic [1:0] FC_OTHER  = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] reply_code;
	} out_item_t;

	typedef struct packed {
		logic [5:0]  ok_digit;
		logic [15:0] timeout_ticks;
		logic [15:0] buffer_limit;
	} cfg_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} result_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b inside {CH_SPACE, [8'h09:8'h0D]});
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b inside {[8'h30:8'h39]});
	endfunction

endpackage

// ===== design/lmtp_reply_parser_top.sv =====
// top level of the lmtp reply parser: config, input register, result register
// The parser takes one request (a reply byte, a timer tick or an end-of-
// stream event) per clock unless a result stalls, and gives at most one
// result per request: the final status of a reply and the code of its first
// line. A request is registered on transfer and parsed against the reply
// state from the input register. Its result is loaded into the output
// register when the request advances, raising out_valid, and can then
// transfer out. Throughput is one request per cycle while no result is
// stalled. The only thing that holds the input back is a result waiting in
// the output register while out_ready is low, and then only while a request
// sits in the input register. Every result clears the reply state so the
// next byte starts a new reply. Configuration (ok digit, tick limit per line,
// byte budget) is written through cfg_we/cfg_index/cfg_data and should change
// only while no request is in flight.
module lmtp_reply_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lrp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output lrp_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	lrp_pkg::cfg_t      cfg_q;
	logic               valid_s1;
	lrp_pkg::in_item_t  item_s1;
	logic               out_valid_q;
	lrp_pkg::out_item_t out_item_q;
	lrp_pkg::result_t   res;
	logic               advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ok_digit      <= lrp_pkg::OK_DIGIT_RST;
			cfg_q.timeout_ticks <= lrp_pkg::TIMEOUT_TICKS_RST;
			cfg_q.buffer_limit  <= lrp_pkg::BUFFER_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lrp_pkg::REG_OK_DIGIT:      cfg_q.ok_digit      <= cfg_data[5:0];
				lrp_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				lrp_pkg::REG_BUFFER_LIMIT:  cfg_q.buffer_limit  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// the registered request moves on whenever the result slot is free
	// or being emptied this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	// parse logic and reply state
	lrp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && res.valid)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid)
			out_item_q <= res.item;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// a stalled result never lets the parser step
	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("parser stepped while result stalled");

	// input held off only while a request sits in the input register
	a_ready_low_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input held off with empty input register");

	// a reported code never exceeds 999, the largest three-digit value
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.reply_code <= 10'd999))
		else $error("reply code out of range");

	// a fresh result is loaded only from a parsed request
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q)) |-> $past(advance && res.valid))
		else $error("result appeared without a parsed request");

endmodule

// ===== design/lrp_core.sv =====
// reply state registers and the per-item parse logic
module lrp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  lrp_pkg::in_item_t  item,
	input  lrp_pkg::cfg_t      cfg,
	output lrp_pkg::result_t   res
);

	logic [2:0]  line_pos_q, line_pos_d;
	logic [9:0]  line_code_q, line_code_d;
	logic [3:0]  line_digit_q, line_digit_d;
	logic [9:0]  first_code_q, first_code_d;
	logic [3:0]  first_digit_q, first_digit_d;
	logic        first_flag_q, first_flag_d;
	logic [1:0]  fourth_class_q, fourth_class_d;
	logic        text_after_q, text_after_d;
	logic        digits_bad_q, digits_bad_d;
	logic [15:0] bytes_used_q, bytes_used_d;
	logic [15:0] tick_q, tick_d;

	logic [7:0]  b;
	logic [13:0] code_mac;
	logic [15:0] tick_inc;
	logic [15:0] bytes_inc;
	logic [15:0] bytes_inc2;
	logic        over_budget;
	logic        line_bad;
	logic [9:0]  code_now;
	logic [3:0]  digit_now;
	logic        emit;
	logic        clr_line;

	assign b         = item.data_byte;
	assign code_mac  = {4'd0, line_code_q} * 14'd10 + {10'd0, b[3:0]};
	assign tick_inc  = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
	assign bytes_inc = (bytes_used_q == 16'hFFFF) ? bytes_used_q : bytes_used_q + 16'd1;
	assign bytes_inc2 = (bytes_inc == 16'hFFFF) ? bytes_inc : bytes_inc + 16'd1;
	assign over_budget = ({1'b0, bytes_used_q} + lrp_pkg::BUDGET_MARGIN) >
		{1'b0, cfg.buffer_limit};
	assign line_bad = (line_pos_q < 3'd3) || digits_bad_q ||
		(fourth_class_q == lrp_pkg::FC_OTHER) ||
		((fourth_class_q == lrp_pkg::FC_ABSENT) && text_after_q);
	assign code_now  = first_flag_q ? line_code_q : first_code_q;
	assign digit_now = first_flag_q ? line_digit_q : first_digit_q;

	always_comb begin
		line_pos_d     = line_pos_q;
		line_code_d    = line_code_q;
		line_digit_d   = line_digit_q;
		first_code_d   = first_code_q;
		first_digit_d  = first_digit_q;
		first_flag_d   = first_flag_q;
		fourth_class_d = fourth_class_q;
		text_after_d   = text_after_q;
		digits_bad_d   = digits_bad_q;
		bytes_used_d   = bytes_used_q;
		tick_d         = tick_q;
		emit           = 1'b0;
		clr_line       = 1'b0;
		res.item.status     = lrp_pkg::ST_EOS;
		res.item.reply_code = first_code_q;

		case (item.req_type)
			lrp_pkg::REQ_TICK: begin
				tick_d = tick_inc;
				if (cfg.timeout_ticks != 16'd0 && tick_inc >= cfg.timeout_ticks) begin
					emit = 1'b1;
					res.item.status = lrp_pkg::ST_TIMEOUT;
				end
			end
			lrp_pkg::REQ_EOS: begin
				emit = 1'b1;
				res.item.status = lrp_pkg::ST_EOS;
			end
			lrp_pkg::REQ_BYTE: begin
				if (over_budget) begin
					emit = 1'b1;
					res.item.status = lrp_pkg::ST_OVERFLOW;
				end else if (b != lrp_pkg::CH_LF) begin
					bytes_used_d = bytes_inc;
					if (line_pos_q < 3'd3) begin
						if (lrp_pkg::is_digit(b)) begin
							line_code_d = code_mac[9:0];
							if (line_pos_q == 3'd0)
								line_digit_d = b[3:0];
						end else begin
							digits_bad_d = 1'b1;
						end
					end else if (line_pos_q == 3'd3) begin
						if (b == lrp_pkg::CH_DASH)
							fourth_class_d = lrp_pkg::FC_DASH;
						else if (b == lrp_pkg::CH_SPACE)
							fourth_class_d = lrp_pkg::FC_SPACE;
						else if (lrp_pkg::is_ws(b))
							fourth_class_d = lrp_pkg::FC_ABSENT;
						else
							fourth_class_d = lrp_pkg::FC_OTHER;
					end else if (!lrp_pkg::is_ws(b)) begin
						text_after_d = 1'b1;
					end
					// position only matters up to the fourth byte
					if (line_pos_q != 3'd4)
						line_pos_d = line_pos_q + 3'd1;
				end else if (line_bad) begin
					emit = 1'b1;
					res.item.status = lrp_pkg::ST_FORMAT;
				end else if (fourth_class_q == lrp_pkg::FC_DASH) begin
					// continuation line: one joining byte plus the LF
					first_code_d  = code_now;
					first_digit_d = digit_now;
					first_flag_d  = 1'b0;
					bytes_used_d  = bytes_inc2;
					clr_line      = 1'b1;
				end else begin
					emit = 1'b1;
					res.item.reply_code = code_now;
					res.item.status = ({2'b11, digit_now} == cfg.ok_digit) ?
						lrp_pkg::ST_OK : lrp_pkg::ST_NOT_OK;
				end
			end
			default: begin
			end
		endcase

		if (clr_line || emit) begin
			line_pos_d     = 3'd0;
			line_code_d    = 10'd0;
			fourth_class_d = lrp_pkg::FC_ABSENT;
			text_after_d   = 1'b0;
			digits_bad_d   = 1'b0;
			tick_d         = 16'd0;
		end
		if (emit) begin
			first_code_d = 10'd0;
			first_flag_d = 1'b1;
			bytes_used_d = 16'd0;
		end
		res.valid = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q     <= 3'd0;
			line_code_q    <= 10'd0;
			line_digit_q   <= 4'd0;
			first_code_q   <= 10'd0;
			first_digit_q  <= 4'd0;
			first_flag_q   <= 1'b1;
			fourth_class_q <= lrp_pkg::FC_ABSENT;
			text_after_q   <= 1'b0;
			digits_bad_q   <= 1'b0;
			bytes_used_q   <= 16'd0;
			tick_q         <= 16'd0;
		end else if (advance) begin
			line_pos_q     <= line_pos_d;
			line_code_q    <= line_code_d;
			line_digit_q   <= line_digit_d;
			first_code_q   <= first_code_d;
			first_digit_q  <= first_digit_d;
			first_flag_q   <= first_flag_d;
			fourth_class_q <= fourth_class_d;
			text_after_q   <= text_after_d;
			digits_bad_q   <= digits_bad_d;
			bytes_used_q   <= bytes_used_d;
			tick_q         <= tick_d;
		end
	end

endmodule
